// ----- src/assert_macros.svh -----
// Assertion macros used by the ARP cache sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ACR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked at every rising edge, reset included.
`define ACR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// ----- src/acr_pkg.sv -----
// Shared types and constants of the ARP cache and responder.
`default_nettype none

package acr_pkg;

    localparam int CACHE_ENTRIES_DEF = 16;

    localparam int IP_W  = 32;
    localparam int MAC_W = 48;
    localparam int OPC_W = 16;

    // Stream payload widths.
    localparam int S_TDATA_W = 160;
    localparam int RES_W     = 131;
    localparam int M_TDATA_W = 136;
    localparam int M_PAD_W   = M_TDATA_W - RES_W;

    // Configuration register indexes.
    localparam logic CFG_OWN_IP  = 1'b0;
    localparam logic CFG_OWN_MAC = 1'b1;

    // ARP opcodes, host order.
    localparam logic [OPC_W-1:0] OP_REQUEST = 16'd1;
    localparam logic [OPC_W-1:0] OP_REPLY   = 16'd2;

    typedef enum logic [1:0] {
        JOB_NONE,
        JOB_LOOKUP,
        JOB_LEARN
    } t_job_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Decoded transaction handed to the sequencer.
    typedef struct packed {
        t_job_kind         kind;
        logic              reply;
        logic [IP_W-1:0]   key;
        logic [MAC_W-1:0]  mac;
    } t_job;

    // Table write strobes and data.
    typedef struct packed {
        logic              ip_we;
        logic              mac_we;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
    } t_tbl_wr;

    // One result transaction.
    typedef struct packed {
        logic              learn_dropped;
        logic [MAC_W-1:0]  lookup_mac;
        logic              lookup_hit;
        logic [IP_W-1:0]   reply_ip;
        logic [MAC_W-1:0]  reply_mac;
        logic              send_reply;
    } t_res;

endpackage

`default_nettype wire

// ----- src/acr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module acr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- src/acr_ctrl.sv -----
// Sequencer: walks the table through one IP comparator, then learns or answers.
`default_nettype none
`include "assert_macros.svh"

module acr_ctrl
    import acr_pkg::*;
#(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF,
    localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1,
    localparam int CW = $clog2(CACHE_ENTRIES + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire t_job              i_job,
    output logic                   o_ready,
    output logic      [IW-1:0]     o_rd_addr,
    input  wire logic [IP_W-1:0]   i_rd_ip,
    input  wire logic [MAC_W-1:0]  i_rd_mac,
    output t_tbl_wr                o_wr,
    output logic      [IW-1:0]     o_wr_addr,
    output t_res                   o_res,
    output logic                   o_res_vld,
    input  wire logic              i_res_rdy
);

    t_state            r_state, n_state;
    t_job              r_job, n_job;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [IW-1:0]     r_pidx, n_pidx;
    logic [CW-1:0]     r_fill, n_fill;
    logic              r_hit, n_hit;
    logic [MAC_W-1:0]  r_fmac, n_fmac;
    logic              r_drop, n_drop;
    logic              match;

    // the shared comparator: entry read last cycle against the key
    assign match = r_pend && (i_rd_ip == r_job.key);

    always_comb begin
        n_state       = r_state;
        n_job         = r_job;
        n_idx         = r_idx;
        n_pend        = 1'b0;
        n_pidx        = r_pidx;
        n_fill        = r_fill;
        n_hit         = r_hit;
        n_fmac        = r_fmac;
        n_drop        = r_drop;
        o_wr.ip_we    = 1'b0;
        o_wr.mac_we   = 1'b0;
        o_wr.ip       = r_job.key;
        o_wr.mac      = r_job.mac;
        o_wr_addr     = r_pidx;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_job  = i_job;
                    n_idx  = '0;
                    n_hit  = 1'b0;
                    n_fmac = '0;
                    n_drop = 1'b0;
                    n_state = (i_job.kind == JOB_NONE) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (match) begin
                    // first match wins
                    if (r_job.kind == JOB_LOOKUP) begin
                        n_hit  = 1'b1;
                        n_fmac = i_rd_mac;
                    end else begin
                        o_wr.mac_we = 1'b1;
                    end
                    n_state = ST_DONE;
                end else if (r_idx < r_fill) begin
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_idx[IW-1:0];
                end else begin
                    // miss: a learn appends, or drops when full
                    if (r_job.kind == JOB_LEARN) begin
                        if (r_fill < CW'(CACHE_ENTRIES)) begin
                            o_wr.ip_we  = 1'b1;
                            o_wr.mac_we = 1'b1;
                            o_wr_addr   = r_fill[IW-1:0];
                            n_fill      = r_fill + 1'b1;
                        end else begin
                            n_drop = 1'b1;
                        end
                    end
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_res_rdy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_idx  <= n_idx;
        r_pidx <= n_pidx;
        r_hit  <= n_hit;
        r_fmac <= n_fmac;
        r_drop <= n_drop;
    end

    assign o_ready   = (r_state == ST_IDLE);
    assign o_rd_addr = r_idx[IW-1:0];
    assign o_res_vld = (r_state == ST_DONE);

    always_comb begin
        o_res.send_reply    = r_job.reply;
        o_res.reply_mac     = r_job.reply ? r_job.mac : '0;
        o_res.reply_ip      = r_job.reply ? r_job.key : '0;
        o_res.lookup_hit    = r_hit;
        o_res.lookup_mac    = r_fmac;
        o_res.learn_dropped = r_drop;
    end

    `ACR_ASSERT(a_fill_bound, r_fill <= CW'(CACHE_ENTRIES), "fill count beyond table size")
    `ACR_ASSERT(a_fill_step, $past(i_rst_n) |-> ((r_fill == $past(r_fill)) || (r_fill == $past(r_fill) + 1'b1)), "fill count moved by more than one")
    `ACR_ASSERT(a_append_room, o_wr.ip_we |-> (r_fill < CW'(CACHE_ENTRIES)), "append into a full table")
    `ACR_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> ((r_state == ST_IDLE) && (r_fill == '0)), "reset left table state")

endmodule

`default_nettype wire

// ----- src/arp_cache_responder_core.sv -----
// Top level of the ARP cache and responder: stream ports, config, table, result register.
`default_nettype none

// ARP cache and responder. Holds up to CACHE_ENTRIES IPv4-to-MAC mappings,
// valid from index 0 up to a fill count that reset clears. An input
// transaction with tuser = 0 is a received ARP packet: a reply (opcode 2)
// learns its sender; a request (opcode 1) whose target IP equals own_ip
// learns its sender and asks for a reply to the sender's MAC and IP; any
// other packet is ignored and returns an all-zero result. Learning updates
// the MAC of the first entry whose IP matches, else appends, else (table
// full) drops the mapping and flags learn_dropped. tuser = 1 is a lookup of
// query_ip returning hit and MAC. Every input transaction yields exactly one
// result transaction.
// Timing: the table sits in one RAM pair with a single registered read
// port, walked one entry per cycle through a single IP comparator. A packet
// or lookup holds s_axis_tready low until its scan (cut short by an early
// hit) ends and its result enters the result register; an ignored packet
// skips the scan. That register lets the next transaction be accepted while
// a result waits on the master side. The user must write own_ip / own_mac
// through the config port only while the block is idle; the block does not
// enforce this; own_mac goes out only on o_own_mac, for the reply framer.

module arp_cache_responder_core
    import acr_pkg::*;
#(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // slave side
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // opcode[15:0], src_ip[47:16], src_mac[95:48],
    // dst_ip[127:96], query_ip[159:128]
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // func[0]
    input  wire logic [0:0]           s_axis_tuser,
    // master side
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // send_reply[0], reply_mac[48:1], reply_ip[80:49], lookup_hit[81],
    // lookup_mac[129:82], learn_dropped[130], zero pad[135:131]
    output logic      [M_TDATA_W-1:0] m_axis_tdata,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_idx,
    input  wire logic [MAC_W-1:0]     i_cfg_data,
    // station MAC, source address for the reply framer
    output logic      [MAC_W-1:0]     o_own_mac
);

    localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    logic [IP_W-1:0]   r_own_ip;
    logic [MAC_W-1:0]  r_own_mac;

    logic [OPC_W-1:0]  opcode;
    logic [IP_W-1:0]   src_ip;
    logic [MAC_W-1:0]  src_mac;
    logic [IP_W-1:0]   dst_ip;
    logic [IP_W-1:0]   query_ip;
    logic              func;
    logic              is_req_for_us;
    t_job              job;
    logic              start;
    logic              ctrl_ready;

    logic [IW-1:0]     rd_addr;
    logic [IP_W-1:0]   rd_ip;
    logic [MAC_W-1:0]  rd_mac;
    t_tbl_wr           tbl_wr;
    logic [IW-1:0]     wr_addr;

    t_res              res;
    logic              res_vld;
    logic              res_rdy;
    logic              r_out_vld;
    t_res              r_out_res;

    // ---- configuration registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip  <= '0;
            r_own_mac <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OWN_IP:  r_own_ip  <= i_cfg_data[IP_W-1:0];
                CFG_OWN_MAC: r_own_mac <= i_cfg_data;
                default:     r_own_ip  <= r_own_ip;
            endcase
        end
    end

    assign o_own_mac = r_own_mac;

    // ---- unpack and classify the incoming transaction ----
    assign opcode   = s_axis_tdata[15:0];
    assign src_ip   = s_axis_tdata[47:16];
    assign src_mac  = s_axis_tdata[95:48];
    assign dst_ip   = s_axis_tdata[127:96];
    assign query_ip = s_axis_tdata[159:128];
    assign func     = s_axis_tuser[0];

    assign is_req_for_us = (opcode == OP_REQUEST) && (dst_ip == r_own_ip);

    always_comb begin
        job.reply = !func && is_req_for_us;
        job.key   = func ? query_ip : src_ip;
        job.mac   = src_mac;
        if (func) begin
            job.kind = JOB_LOOKUP;
        end else if ((opcode == OP_REPLY) || is_req_for_us) begin
            job.kind = JOB_LEARN;
        end else begin
            job.kind = JOB_NONE;
        end
    end

    assign s_axis_tready = ctrl_ready;
    assign start         = s_axis_tvalid && ctrl_ready;

    // ---- table: IP and MAC columns share one address ----
    acr_ram #(
        .WIDTH (IP_W),
        .DEPTH (CACHE_ENTRIES)
    ) u_ip_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_wr.ip_we),
        .i_waddr (wr_addr),
        .i_wdata (tbl_wr.ip),
        .i_raddr (rd_addr),
        .o_rdata (rd_ip)
    );

    acr_ram #(
        .WIDTH (MAC_W),
        .DEPTH (CACHE_ENTRIES)
    ) u_mac_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_wr.mac_we),
        .i_waddr (wr_addr),
        .i_wdata (tbl_wr.mac),
        .i_raddr (rd_addr),
        .o_rdata (rd_mac)
    );

    // ---- sequencer ----
    acr_ctrl #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_job     (job),
        .o_ready   (ctrl_ready),
        .o_rd_addr (rd_addr),
        .i_rd_ip   (rd_ip),
        .i_rd_mac  (rd_mac),
        .o_wr      (tbl_wr),
        .o_wr_addr (wr_addr),
        .o_res     (res),
        .o_res_vld (res_vld),
        .i_res_rdy (res_rdy)
    );

    // ---- result register: decouples the master side ----
    assign res_rdy = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_vld && res_rdy) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_vld && res_rdy) begin
            r_out_res <= res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}},
                            r_out_res.learn_dropped,
                            r_out_res.lookup_mac,
                            r_out_res.lookup_hit,
                            r_out_res.reply_ip,
                            r_out_res.reply_mac,
                            r_out_res.send_reply};

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the ARP cache and responder core.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import acr_pkg::*;

    localparam int N_ENTRIES = CACHE_ENTRIES_DEF;

    // One input transaction, unpacked.
    typedef struct {
        bit             func;
        bit [OPC_W-1:0] opcode;
        bit [IP_W-1:0]  src_ip;
        bit [MAC_W-1:0] src_mac;
        bit [IP_W-1:0]  dst_ip;
        bit [IP_W-1:0]  query_ip;
    } t_arp_item;

    // Mirror of the cache table and the two station registers. Each accepted
    // transaction is run against the mirror and its result queued; result
    // transactions leaving the block are checked against the queue head.
    class arp_cache_mirror;
        bit [IP_W-1:0]  ip_tbl  [N_ENTRIES];
        bit [MAC_W-1:0] mac_tbl [N_ENTRIES];
        int             n_valid;
        bit [IP_W-1:0]  own_ip;
        bit [MAC_W-1:0] own_mac;
        t_res           results_due [$];
        int unsigned    n_errors;

        function void set_reg(logic idx, bit [MAC_W-1:0] value);
            if (idx == CFG_OWN_IP) begin
                own_ip = value[IP_W-1:0];
            end else begin
                own_mac = value;
            end
        endfunction

        // First valid slot holding ip, or -1.
        function int find_ip(bit [IP_W-1:0] ip);
            for (int i = 0; i < n_valid; i++) begin
                if (ip_tbl[i] == ip) return i;
            end
            return -1;
        endfunction

        // Returns 1 when the mapping had to be dropped (table full, no match).
        function bit learn(bit [IP_W-1:0] ip, bit [MAC_W-1:0] mac);
            int slot;
            slot = find_ip(ip);
            if (slot >= 0) begin
                mac_tbl[slot] = mac;
                return 1'b0;
            end
            if (n_valid < N_ENTRIES) begin
                ip_tbl[n_valid]  = ip;
                mac_tbl[n_valid] = mac;
                n_valid++;
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function t_res predict_result(t_arp_item it);
            t_res r;
            int   slot;
            r = '0;
            if (it.func) begin
                slot = find_ip(it.query_ip);
                if (slot >= 0) begin
                    r.lookup_hit = 1'b1;
                    r.lookup_mac = mac_tbl[slot];
                end
            end else if (it.opcode == OP_REPLY) begin
                r.learn_dropped = learn(it.src_ip, it.src_mac);
            end else if (it.opcode == OP_REQUEST && it.dst_ip == own_ip) begin
                r.learn_dropped = learn(it.src_ip, it.src_mac);
                r.send_reply    = 1'b1;
                r.reply_mac     = it.src_mac;
                r.reply_ip      = it.src_ip;
            end
            return r;
        endfunction

        function void take_item(t_arp_item it);
            results_due.push_back(predict_result(it));
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                n_errors++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata);
            t_res got;
            t_res want;
            got = tdata[RES_W-1:0];
            if (results_due.size() == 0) begin
                $error("result transaction with no item outstanding: %h", tdata);
                n_errors++;
                return;
            end
            want = results_due.pop_front();
            compare_field("send_reply",    want.send_reply,    got.send_reply);
            compare_field("reply_mac",     want.reply_mac,     got.reply_mac);
            compare_field("reply_ip",      want.reply_ip,      got.reply_ip);
            compare_field("lookup_hit",    want.lookup_hit,    got.lookup_hit);
            compare_field("lookup_mac",    want.lookup_mac,    got.lookup_mac);
            compare_field("learn_dropped", want.learn_dropped, got.learn_dropped);
            compare_field("pad",           '0, tdata[M_TDATA_W-1:RES_W]);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // opcode, src_ip, src_mac, dst_ip, query_ip (LSB first)
    logic [S_TDATA_W-1:0] s_axis_tdata;
    // func
    logic [0:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // send_reply, reply_mac, reply_ip, lookup_hit, lookup_mac, learn_dropped, pad
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 i_cfg_we;
    logic                 i_cfg_idx;
    logic [MAC_W-1:0]     i_cfg_data;
    logic [MAC_W-1:0]     o_own_mac;

    arp_cache_mirror mirror = new();

    // Idle controls: sender gap chance per transaction (percent), and a quiet
    // tail where neither side idles.
    int unsigned gap_pct    = 20;
    bit          quiet_tail = 1'b0;

    arp_cache_responder_core #(
        .CACHE_ENTRIES (N_ENTRIES)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_own_mac     (o_own_mac)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: the slowest legal run is well under a fifth of this.
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Result side: sample on the rising edge, check every accepted transaction and o_own_mac.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            mirror.check_result(m_axis_tdata);
        end
        if (i_rst_n) begin
            mirror.compare_field("own_mac", mirror.own_mac, o_own_mac);
        end
    end

    // Receiver backpressure: ready runs of random length, broken by stalls of
    // random length; some runs skip the stall so long open stretches occur.
    initial begin
        int unsigned run;
        m_axis_tready = 1'b0;
        forever begin
            run = $urandom_range(1, 40);
            repeat (run) begin
                @(negedge i_clk);
                m_axis_tready = 1'b1;
            end
            if (!quiet_tail && $urandom_range(0, 3) != 0) begin
                run = $urandom_range(1, 16);
                repeat (run) begin
                    @(negedge i_clk);
                    m_axis_tready = 1'b0;
                end
            end
        end
    end

    // Present one transaction at the falling edge, hold until accepted, then
    // hand it to the mirror at the accepting edge.
    task automatic send_item(t_arp_item it);
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = it.func;
        s_axis_tdata  = {it.query_ip, it.dst_ip, it.src_mac, it.src_ip, it.opcode};
        do @(posedge i_clk); while (!s_axis_tready);
        mirror.take_item(it);
    endtask

    // Sender gap whose length is set by n; data is scrambled while valid is low.
    task automatic pause_sender(int unsigned n);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = {$urandom, $urandom, $urandom, $urandom, $urandom};
        s_axis_tuser  = 1'($urandom);
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic issue(t_arp_item it);
        if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
            pause_sender($urandom_range(1, 16));
        end
        send_item(it);
    endtask

    // Hold the sender off until every predicted result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (mirror.results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, bit [MAC_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        mirror.set_reg(idx, value);
    endtask

    function automatic bit [MAC_W-1:0] rand_mac();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 16) return '1;
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Mostly addresses already in the table so updates and hits dominate.
    function automatic bit [IP_W-1:0] pick_ip();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65 && mirror.n_valid > 0) begin
            return mirror.ip_tbl[$urandom_range(0, mirror.n_valid - 1)];
        end
        if (r < 75) return $urandom_range(0, 1) ? '1 : '0;
        return $urandom;
    endfunction

    function automatic t_arp_item make_packet(bit [OPC_W-1:0] op, bit [IP_W-1:0] sip,
                                              bit [MAC_W-1:0] smac, bit [IP_W-1:0] tip);
        t_arp_item it;
        it.func     = 1'b0;
        it.opcode   = op;
        it.src_ip   = sip;
        it.src_mac  = smac;
        it.dst_ip   = tip;
        it.query_ip = $urandom;
        return it;
    endfunction

    // Lookup with junk in the packet fields; none of it may be learned.
    function automatic t_arp_item make_lookup(bit [IP_W-1:0] q);
        t_arp_item it;
        it = make_packet(OP_REPLY, $urandom, rand_mac(), $urandom);
        it.func     = 1'b1;
        it.query_ip = q;
        return it;
    endfunction

    function automatic t_arp_item random_item();
        t_arp_item   it;
        int unsigned r;
        it = make_packet(16'($urandom), pick_ip(), rand_mac(), $urandom);
        r  = $urandom_range(0, 99);
        if (r < 30) begin
            it.func     = 1'b1;
            it.query_ip = pick_ip();
        end else if (r < 55) begin
            it.opcode = OP_REPLY;
        end else if (r < 80) begin
            it.opcode = OP_REQUEST;
            it.dst_ip = mirror.own_ip;
        end else if (r < 88) begin
            // request aimed one bit away from us
            it.opcode = OP_REQUEST;
            it.dst_ip = mirror.own_ip ^ (32'd1 << $urandom_range(0, 31));
        end else if (r < 93) begin
            // opcodes in network byte order must not be recognized
            it.opcode = $urandom_range(0, 1) ? 16'h0100 : 16'h0200;
        end
        return it;
    endfunction

    initial begin
        t_arp_item it;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_OWN_IP;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_reg(CFG_OWN_IP,  32'hC0A8_0A01);
        write_reg(CFG_OWN_MAC, '1);

        // Directed: empty table, extremes, every opcode class, then fill to
        // full and exercise drop / update-while-full.
        issue(make_lookup('0));
        issue(make_packet(OP_REPLY, '0, '0, '1));
        issue(make_packet(OP_REPLY, '1, '1, '0));
        issue(make_packet(OP_REQUEST, 32'hC0A8_0A37, 48'h0200_1122_3344, 32'hC0A8_0A01));
        issue(make_packet(OP_REQUEST, 32'hC0A8_0A38, 48'h0200_5566_7788, 32'hC0A8_0A02));
        issue(make_packet(16'h0000, 32'h0A0A_0A0A, rand_mac(), 32'hC0A8_0A01));
        issue(make_packet(16'hFFFF, 32'h0A0A_0A0B, rand_mac(), 32'hC0A8_0A01));
        issue(make_packet(16'h0200, 32'h0A0A_0A0C, rand_mac(), 32'hC0A8_0A01));
        issue(make_lookup('1));
        issue(make_packet(OP_REPLY, '0, 48'hA5A5_5A5A_0F0F, $urandom));
        issue(make_lookup('0));
        for (int k = 0; k < N_ENTRIES - 3; k++) begin
            issue(make_packet(OP_REPLY, 32'h0A00_0100 + k, rand_mac(), $urandom));
        end
        issue(make_packet(OP_REPLY, 32'h0B00_0001, rand_mac(), $urandom));
        issue(make_packet(OP_REQUEST, 32'h0B00_0002, rand_mac(), 32'hC0A8_0A01));
        issue(make_packet(OP_REPLY, '1, 48'h1234_5678_9ABC, $urandom));
        issue(make_lookup(32'h0B00_0001));
        issue(make_lookup(32'h0A00_0105));

        // Random phases, each with its own station registers and idle mix.
        for (int phase = 0; phase < 4; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    write_reg(CFG_OWN_IP, '0);
                    write_reg(CFG_OWN_MAC, '0);
                    gap_pct = 25;
                end
                1: begin
                    write_reg(CFG_OWN_IP, '1);
                    write_reg(CFG_OWN_MAC, rand_mac());
                    gap_pct = 0;
                end
                2: begin
                    write_reg(CFG_OWN_IP, $urandom);
                    write_reg(CFG_OWN_MAC, rand_mac());
                    gap_pct = 40;
                end
                default: begin
                    // own address equal to a cached one
                    write_reg(CFG_OWN_IP, mirror.ip_tbl[$urandom_range(0, N_ENTRIES - 1)]);
                    write_reg(CFG_OWN_MAC, '1);
                    gap_pct    = 0;
                    quiet_tail = 1'b1;
                end
            endcase
            for (int n = 0; n < 420; n++) begin
                it = random_item();
                issue(it);
                if (!quiet_tail && $urandom_range(0, 199) == 0) drain_results();
            end
        end

        drain_results();
        repeat (N_ENTRIES + 8) @(posedge i_clk);
        if (mirror.n_errors == 0 && mirror.results_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- arp_cache_responder_core.f -----
+incdir+src
src/acr_pkg.sv
src/acr_ram.sv
src/acr_ctrl.sv
src/arp_cache_responder_core.sv
dv/tb.sv
